[hw/rtl/smfx_pkg.sv]
// Shared constants, types and helpers for the sign-magnitude fixed-point ALU.
package smfx_pkg;

   localparam int FRAC_BITS = 14;
   localparam int MAG_W     = FRAC_BITS + 1;
   localparam int SUM_W     = MAG_W + 2;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int WIDE_W    = MAG_W + 2;
   localparam int DIV_STEPS = MAG_W;

   localparam logic [MAG_W-1:0]  MAX_MAG   = {MAG_W{1'b1}};
   localparam logic [PROD_W:0]   FRAC_MASK = {{(PROD_W + 1 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   // One item in flight. Items that need no division carry their final
   // magnitude in mag; a division in progress shifts its quotient into mag.
   typedef struct packed {
      logic             run;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] rem;
      logic [MAG_W-1:0] dvs;
      logic             nbit;
   } tok_type;

   function automatic logic [MAG_W-1:0] sat_mag(input logic [WIDE_W-1:0] v);
      logic [MAG_W-1:0] r;
      begin
         if (v > WIDE_W'(MAX_MAG)) begin
            r = MAX_MAG;
         end else begin
            r = v[MAG_W-1:0];
         end
         return r;
      end
   endfunction

endpackage

[hw/rtl/smfx_front.sv]
// Front stage: operand decode, add/subtract, multiply and divide setup.
module smfx_front
   import smfx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0]           in_func,
   input  logic                 in_x_sign,
   input  logic                 in_x_int,
   input  logic [FRAC_BITS-1:0] in_x_frac,
   input  logic                 in_y_sign,
   input  logic                 in_y_int,
   input  logic [FRAC_BITS-1:0] in_y_frac,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tok_type              out_tok
);

   logic              valid_ff;
   logic              valid_in;
   tok_type           tok_ff;
   tok_type           tok_in;

   logic [MAG_W-1:0]  mx;
   logic [MAG_W-1:0]  my;
   logic              sy_eff;
   logic [SUM_W-1:0]  vx;
   logic [SUM_W-1:0]  vy;
   logic [SUM_W-1:0]  sum;
   logic              as_neg;
   logic [SUM_W-1:0]  as_abs;
   logic [PROD_W-1:0] prod;
   logic              mul_neg;
   logic [PROD_W:0]   prod_rnd;
   logic              div_zero;
   logic              div_ovf;
   func_type          func;

   assign func = func_type'(in_func);
   assign mx   = {in_x_int, in_x_frac};
   assign my   = {in_y_int, in_y_frac};

   // add and subtract in two's complement, one guard bit above the magnitude
   assign sy_eff = in_y_sign ^ (func == FUNC_SUB);
   assign vx     = in_x_sign ? (SUM_W'(0) - SUM_W'(mx)) : SUM_W'(mx);
   assign vy     = sy_eff ? (SUM_W'(0) - SUM_W'(my)) : SUM_W'(my);
   assign sum    = vx + vy;
   assign as_neg = sum[SUM_W-1];
   assign as_abs = as_neg ? (SUM_W'(0) - sum) : sum;

   // product floors toward minus infinity: round the magnitude up when negative
   assign prod     = mx * my;
   assign mul_neg  = (in_x_sign ^ in_y_sign) && (prod != '0);
   assign prod_rnd = {1'b0, prod} + (mul_neg ? FRAC_MASK : '0);

   // quotient at or above 2^MAG_W saturates: mx*2^F >= my*2^MAG_W
   assign div_zero = (my == '0);
   assign div_ovf  = {1'b0, mx} >= {my, 1'b0};

   always_comb begin
      tok_in      = '0;
      tok_in.rem  = {1'b0, mx[MAG_W-1:1]};
      tok_in.dvs  = my;
      tok_in.nbit = mx[0];
      case (func)
         FUNC_ADD, FUNC_SUB: begin
            tok_in.neg = as_neg;
            tok_in.mag = sat_mag(WIDE_W'(as_abs[SUM_W-2:0]));
         end
         FUNC_MUL: begin
            tok_in.neg = mul_neg;
            tok_in.mag = sat_mag(prod_rnd[PROD_W:FRAC_BITS]);
         end
         FUNC_DIV: begin
            if (div_zero) begin
               tok_in.neg = in_x_sign && (mx != '0);
               tok_in.mag = MAX_MAG;
            end else if (div_ovf) begin
               tok_in.neg = in_x_sign ^ in_y_sign;
               tok_in.mag = MAX_MAG;
            end else begin
               tok_in.run = 1'b1;
               tok_in.neg = in_x_sign ^ in_y_sign;
            end
         end
         default: begin
            tok_in.mag = '0;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tok_ff <= tok_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule

[hw/rtl/smfx_div_cell.sv]
// One restoring-division cell: resolves one quotient bit per item.
module smfx_div_cell
   import smfx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  tok_type in_tok,
   output logic    out_valid,
   input  logic    out_ready,
   output tok_type out_tok
);

   logic           valid_ff;
   logic           valid_in;
   tok_type        tok_ff;
   tok_type        tok_in;
   logic [MAG_W:0] rem_sh;
   logic [MAG_W:0] diff;
   logic           ge;

   assign rem_sh = {in_tok.rem, in_tok.nbit};
   assign diff   = rem_sh - {1'b0, in_tok.dvs};
   assign ge     = rem_sh >= {1'b0, in_tok.dvs};

   always_comb begin
      tok_in = in_tok;
      if (in_tok.run) begin
         tok_in.rem  = ge ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
         tok_in.mag  = {in_tok.mag[MAG_W-2:0], ge};
         tok_in.nbit = 1'b0;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tok_ff <= tok_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

   // partial remainder stays below the divisor throughout a division
   a_rem_below_dvs: assert property (@(posedge clock) disable iff (reset)
      valid_ff && tok_ff.run |-> tok_ff.rem < tok_ff.dvs)
      else $error("division remainder not below divisor");

endmodule

[hw/rtl/sign_magnitude_fixed_point_alu.sv]
// Top level of the saturating sign-magnitude Q1.F fixed-point ALU.
//
// Usage:
//   Request channel (req_*): req_func selects add, subtract, multiply or
//   divide; the two operands arrive as sign, integer bit and fraction bits.
//   A transfer happens at a rising edge with req_valid high and req_stall low.
//   Response channel (rsp_*): sign, integer bit and fraction bits of the
//   saturated result; a transfer happens with rsp_valid high, rsp_stall low.
//   Every request gives exactly one response, in request order.
// Stages and throughput:
//   A request passes one front stage (decode, add/subtract, multiply), a
//   chain of 15 division cells that each resolve one quotient bit, and the
//   output register. All operations travel the same chain, so order is
//   kept. One transfer per cycle is sustained while rsp_stall stays low.
// Reset (synchronous, active high) empties every stage; no item survives.
// Stall: each stage advances when it is empty or its successor advances, so
//   bubbles close up; a stalled response holds and the chain fills behind it
//   before req_stall rises.
module sign_magnitude_fixed_point_alu
   import smfx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic                 req_x_sign,
   input  logic                 req_x_int,
   input  logic [FRAC_BITS-1:0] req_x_frac,
   input  logic                 req_y_sign,
   input  logic                 req_y_int,
   input  logic [FRAC_BITS-1:0] req_y_frac,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_r_sign,
   output logic                 rsp_r_int,
   output logic [FRAC_BITS-1:0] rsp_r_frac
);

   // position 0 is the front stage, positions 1..DIV_STEPS the division cells
   logic [DIV_STEPS:0] chain_valid;
   logic [DIV_STEPS:0] chain_ready;
   tok_type            chain_tok [DIV_STEPS+1];
   logic               front_ready;
   logic               out_ready;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_sign_ff;
   logic [MAG_W-1:0]   rsp_mag_ff;
   tok_type            last_tok;

   smfx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_func   (req_func),
      .in_x_sign (req_x_sign),
      .in_x_int  (req_x_int),
      .in_x_frac (req_x_frac),
      .in_y_sign (req_y_sign),
      .in_y_int  (req_y_int),
      .in_y_frac (req_y_frac),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_tok   (chain_tok[0])
   );

   // row of division cells; cell k takes from position k and feeds k+1
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
      smfx_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_tok    (chain_tok[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_tok   (chain_tok[k+1])
      );
   end

   // output register: load whenever empty or the held response transfers
   assign out_ready              = !rsp_valid_ff || !rsp_stall;
   assign chain_ready[DIV_STEPS] = out_ready;
   assign last_tok               = chain_tok[DIV_STEPS];
   assign rsp_valid_in           = out_ready ? chain_valid[DIV_STEPS] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // drop the sign of a zero result
   always_ff @(posedge clock) begin
      if (out_ready && chain_valid[DIV_STEPS]) begin
         rsp_sign_ff <= last_tok.neg && (last_tok.mag != '0);
         rsp_mag_ff  <= last_tok.mag;
      end
   end

   assign req_stall  = !front_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_r_sign = rsp_sign_ff;
   assign rsp_r_int  = rsp_mag_ff[MAG_W-1];
   assign rsp_r_frac = rsp_mag_ff[FRAC_BITS-1:0];

   a_no_neg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_r_sign && !rsp_r_int && (rsp_r_frac == '0)))
      else $error("negative zero on response");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&chain_valid) && rsp_valid && rsp_stall)
      else $error("request stalled with room in the chain");

   a_full_chain_stalls: assert property (@(posedge clock) disable iff (reset)
      (&chain_valid) && rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken into a full stalled chain");

   a_drain_shifts: assert property (@(posedge clock) disable iff (reset)
      chain_valid[DIV_STEPS] && out_ready |=> rsp_valid)
      else $error("finished item lost before output register");

endmodule
